FILE: sv/etur_pkg.sv
// shared types and constants for the edge timed uart receiver
package etur_pkg;

    typedef logic [1:0] action_t;

    localparam action_t ACT_FALL    = 2'd0;
    localparam action_t ACT_RISE    = 2'd1;
    localparam action_t ACT_TIMEOUT = 2'd2;
    localparam action_t ACT_READ    = 2'd3;

    localparam int DELTA_W   = 24;
    localparam int BAUD_W    = 13;
    localparam int HALF_W    = 12;
    localparam int PROD_W    = HALF_W + BAUD_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FRAC_BITS = 12;

    localparam logic [BAUD_W-1:0] BAUD_RESET = 13'd40;
    localparam logic [SUM_W-1:0]  ROUND_HALF = 26'd2048;
    localparam logic [3:0]        WORD_BITS  = 4'd9;
    localparam logic [7:0]        ABORT_BITS = 8'd10;
    localparam logic [7:0]        TOUT_BITS  = 8'd11;
    localparam logic [7:0]        IDLE_SHIFT = 8'hFF;
    localparam logic [7:0]        SAT_BITS   = 8'hFF;

endpackage

FILE: sv/edge_timed_uart_receiver_unit.sv
// top level of the edge timed uart receiver: gap scaling, word tracking, byte ring
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid/cfg_ready    baud_factor
//   in       in         in_valid/in_ready      action, time_delta
//   out      out        out_valid/out_ready    read_data, read_valid, byte_stored, byte_dropped
//
// edge and timeout items make two passes through the shared 12x13 multiplier
// (low then high half of time_delta), then an update state, then return to idle.
// read items pass through a read state and a result state, as the ram read is registered.
// the final cycle of an item waits while the output register still holds an untaken result.
// cfg writes are always taken. reset clears word state and both ring pointers.
module edge_timed_uart_receiver_unit #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [etur_pkg::BAUD_W-1:0]       baud_factor,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  etur_pkg::action_t                 action,
    input  logic [etur_pkg::DELTA_W-1:0]      time_delta,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        read_data,
    output logic                              read_valid,
    output logic                              byte_stored,
    output logic                              byte_dropped
);

    import etur_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_LO = 3'd1;
    localparam logic [2:0] S_MUL_HI = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RDONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [BAUD_W-1:0]  baud_reg;
    action_t            act_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [SUM_W-FRAC_BITS-1:0] acc_reg, acc_next;
    logic [7:0]         bits_reg, bits_next;

    logic               in_word_reg, in_word_next;
    logic [3:0]         count_reg, count_next;
    logic [7:0]         shift_reg, shift_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         read_data_reg, read_data_next;
    logic               read_valid_reg, read_valid_next;
    logic               stored_reg, stored_next;
    logic               dropped_reg, dropped_next;

    logic [HALF_W-1:0]  mul_a;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   sum;

    logic               slot_free;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rd_data;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;

    logic [7:0]         bits_eff;
    logic [4:0]         count_sum;
    logic [3:0]         count_new;
    logic               word_upd;
    logic [3:0]         count_upd;
    logic [7:0]         shift_upd;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign read_valid   = read_valid_reg;
    assign byte_stored  = stored_reg;
    assign byte_dropped = dropped_reg;

    assign slot_free  = !out_valid_reg || out_ready;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    // shared multiplier: low half first, rounded and scaled, then high half on top
    assign mul_a = (state_reg == S_MUL_LO) ? delta_reg[HALF_W-1:0]
                                           : delta_reg[DELTA_W-1:HALF_W];
    assign prod  = PROD_W'(mul_a * baud_reg);
    assign sum   = (state_reg == S_MUL_LO) ? SUM_W'(prod) + ROUND_HALF
                                           : SUM_W'(prod) + SUM_W'(acc_reg);

    // word tracking for one edge or timeout
    always_comb
    begin
        bits_eff  = (bits_reg == 8'd0) ? 8'd1 : bits_reg;
        count_sum = 5'(count_reg) + 5'(bits_eff[3:0]);
        count_new = (count_sum >= 5'(WORD_BITS)) ? WORD_BITS : count_sum[3:0];
        word_upd  = in_word_reg;
        count_upd = count_reg;
        shift_upd = shift_reg;
        if (!in_word_reg && act_reg == ACT_FALL)
        begin
            word_upd  = 1'b1;
            count_upd = 4'd0;
            shift_upd = IDLE_SHIFT;
        end
        else if (in_word_reg && act_reg != ACT_TIMEOUT)
        begin
            if (bits_eff >= ABORT_BITS)
            begin
                word_upd = 1'b0;
            end
            else
            begin
                count_upd = count_new;
                // a rise closes the zero data bits that the gap covered
                for (int k = 0; k < 8; k++)
                begin
                    if (act_reg == ACT_RISE && count_reg <= 4'(k + 1)
                        && 4'(k + 1) < count_new)
                    begin
                        shift_upd[k] = 1'b0;
                    end
                end
            end
        end
        else if (in_word_reg && act_reg == ACT_TIMEOUT && bits_reg > TOUT_BITS)
        begin
            count_upd = WORD_BITS;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        bits_next       = bits_reg;
        in_word_next    = in_word_reg;
        count_next      = count_reg;
        shift_next      = shift_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;
        read_valid_next = read_valid_reg;
        stored_next     = stored_reg;
        dropped_next    = dropped_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACT_READ) ? S_READ : S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                acc_next   = sum[SUM_W-1:FRAC_BITS];
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                bits_next  = (|sum[SUM_W-1:8]) ? SAT_BITS : sum[7:0];
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    in_word_next    = word_upd;
                    count_next      = count_upd;
                    shift_next      = shift_upd;
                    out_valid_next  = 1'b1;
                    read_data_next  = 8'd0;
                    read_valid_next = 1'b0;
                    stored_next     = 1'b0;
                    dropped_next    = 1'b0;
                    if (count_upd >= WORD_BITS)
                    begin
                        if (wr_ptr_inc != rd_ptr_reg)
                        begin
                            ram_we      = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                            stored_next = 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                        in_word_next = (act_reg == ACT_FALL);
                        count_next   = 4'd0;
                        shift_next   = IDLE_SHIFT;
                    end
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_RDONE;
            end
            S_RDONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    stored_next     = 1'b0;
                    dropped_next    = 1'b0;
                    read_data_next  = 8'd0;
                    read_valid_next = 1'b0;
                    if (wr_ptr_reg != rd_ptr_reg)
                    begin
                        read_data_next  = ram_rd_data;
                        read_valid_next = 1'b1;
                        rd_ptr_next     = rd_ptr_inc;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            baud_reg      <= BAUD_RESET;
            in_word_reg   <= 1'b0;
            count_reg     <= 4'd0;
            shift_reg     <= IDLE_SHIFT;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_word_reg   <= in_word_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                baud_reg <= baud_factor;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= action;
            delta_reg <= time_delta;
        end
        acc_reg        <= acc_next;
        bits_reg       <= bits_next;
        read_data_reg  <= read_data_next;
        read_valid_reg <= read_valid_next;
        stored_reg     <= stored_next;
        dropped_reg    <= dropped_next;
    end

    etur_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (shift_upd),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: sv/etur_ram.sv
// generic single write port ram with registered read
module etur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
